// ----- design/dcd_pkg.sv -----
// Shared opcodes and field widths for the deadlock cycle detector.
package dcd_pkg;
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DETECT = 2'd2;

  localparam int unsigned NodeW  = 5;
  localparam int unsigned CountW = 6;
endpackage

// ----- design/dcd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module dcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/deadlock_cycle_detector.sv -----
// Deadlock cycle detector: adjacency matrix in RAM, depth-first walk with a RAM stack.
//
//  channel   dir  fields
//  s_axis    in   tdata = opcode[1:0], from_node[6:2], to_node[11:7]
//  m_axis    out  tdata = node[4:0], cycle_number[10:5]; tlast = last_of_cycle;
//                 tuser = done_res
//  cfg       in   cfg_wr_data_i = node_count, written when cfg_wr_en_i is high
//
// Clear and unused opcodes finish in the idle state; add edge reads the row,
// then writes it back. Detect walks the roots in order, scans the neighbor
// slots of each visited node, pops finished nodes, and scans the stack entries
// when a cycle is reported, then closes with a done result.
// Reset empties the graph at once through per-row valid bits.
// Input is held off until the current request is done; result stalls pause the walk.
module deadlock_cycle_detector
  import dcd_pkg::*;
#(
  parameter int unsigned NODES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [5:0]  cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // opcode[1:0], from_node[6:2], to_node[11:7]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // node[4:0], cycle_number[10:5]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // done_res
);
  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned CW = IW + 1;
  localparam logic [8:0]  NodesW = 9'(NODES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADDWR = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [5:0]        node_count_q;
  logic [NODES-1:0]  row_valid_q, row_valid_d;
  logic [NODES-1:0]  visited_q, visited_d;
  logic [NODES-1:0]  onstack_q, onstack_d;
  logic [CW-1:0]     depth_q, depth_d;
  logic [CW-1:0]     root_q, root_d;
  logic [IW-1:0]     top_node_q, top_node_d;
  logic [CW-1:0]     top_cur_q, top_cur_d;
  logic [IW-1:0]     target_q, target_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              found_q, found_d;
  logic [CountW-1:0] total_q, total_d;
  logic [IW-1:0]     add_from_q, add_from_d;
  logic [IW-1:0]     add_to_q, add_to_d;

  logic              out_valid_q;
  logic [NodeW-1:0]  out_node_q;
  logic              out_last_q;
  logic [CountW-1:0] out_num_q;
  logic              out_done_q;

  logic              emit;
  logic [NodeW-1:0]  emit_node;
  logic              emit_last;
  logic              emit_done;
  logic              out_free;

  // adjacency RAM
  logic              adj_we, adj_re;
  logic [IW-1:0]     adj_waddr, adj_raddr;
  logic [NODES-1:0]  adj_wdata, adj_rdata;
  // walk stack RAMs (node and neighbor cursor)
  logic              nd_we, nd_re, cur_we;
  logic [IW-1:0]     nd_waddr, nd_raddr, cur_waddr;
  logic [IW-1:0]     nd_wdata, nd_rdata;
  logic [CW-1:0]     cur_wdata, cur_rdata;

  logic [1:0]        in_op;
  logic [NodeW-1:0]  in_from, in_to;
  logic [CW-1:0]     n_eff;
  logic [NODES-1:0]  top_row;
  logic [IW-1:0]     v_idx;

  assign in_op   = s_axis_tdata[1:0];
  assign in_from = s_axis_tdata[6:2];
  assign in_to   = s_axis_tdata[11:7];

  assign n_eff    = ({3'b0, node_count_q} > NodesW) ? CW'(NodesW) : CW'(node_count_q);
  assign top_row  = row_valid_q[top_node_q] ? adj_rdata : '0;
  assign v_idx    = top_cur_q[IW-1:0];
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  dcd_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .re_i(adj_re), .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  dcd_ram #(.WIDTH(IW), .DEPTH(NODES)) u_node_ram (
    .clk_i, .we_i(nd_we), .waddr_i(nd_waddr), .wdata_i(nd_wdata),
    .re_i(nd_re), .raddr_i(nd_raddr), .rdata_o(nd_rdata)
  );

  dcd_ram #(.WIDTH(CW), .DEPTH(NODES)) u_cur_ram (
    .clk_i, .we_i(cur_we), .waddr_i(cur_waddr), .wdata_i(cur_wdata),
    .re_i(nd_re), .raddr_i(nd_raddr), .rdata_o(cur_rdata)
  );

  always_comb begin
    state_d     = state_q;
    row_valid_d = row_valid_q;
    visited_d   = visited_q;
    onstack_d   = onstack_q;
    depth_d     = depth_q;
    root_d      = root_q;
    top_node_d  = top_node_q;
    top_cur_d   = top_cur_q;
    target_d    = target_q;
    idx_d       = idx_q;
    found_d     = found_q;
    total_d     = total_q;
    add_from_d  = add_from_q;
    add_to_d    = add_to_q;

    adj_we    = 1'b0;
    adj_waddr = add_from_q;
    adj_wdata = '0;
    adj_re    = 1'b0;
    adj_raddr = top_node_q;
    nd_we     = 1'b0;
    nd_waddr  = '0;
    nd_wdata  = '0;
    nd_re     = 1'b0;
    nd_raddr  = '0;
    cur_we    = 1'b0;
    cur_waddr = '0;
    cur_wdata = '0;

    emit      = 1'b0;
    emit_node = '0;
    emit_last = 1'b0;
    emit_done = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_op)
            OP_CLEAR: begin
              row_valid_d = '0;
              visited_d   = '0;
              onstack_d   = '0;
              depth_d     = '0;
            end
            OP_ADD: begin
              if (({4'b0, in_from} < NodesW) && ({4'b0, in_to} < NodesW)) begin
                adj_re     = 1'b1;
                adj_raddr  = IW'(in_from);
                add_from_d = IW'(in_from);
                add_to_d   = IW'(in_to);
                state_d    = S_ADDWR;
              end
            end
            OP_DETECT: begin
              visited_d = '0;
              onstack_d = '0;
              total_d   = '0;
              root_d    = '0;
              state_d   = S_ROOT;
            end
            default: ;
          endcase
        end
      end

      S_ADDWR: begin
        adj_we    = 1'b1;
        adj_wdata = (row_valid_q[add_from_q] ? adj_rdata : '0)
                    | (NODES'(1) << add_to_q);
        row_valid_d[add_from_q] = 1'b1;
        state_d = S_IDLE;
      end

      S_ROOT: begin
        if (root_q >= n_eff) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_done = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (visited_q[root_q[IW-1:0]]) begin
          root_d = root_q + 1'b1;
        end else begin
          visited_d[root_q[IW-1:0]] = 1'b1;
          onstack_d[root_q[IW-1:0]] = 1'b1;
          nd_we      = 1'b1;
          nd_waddr   = '0;
          nd_wdata   = root_q[IW-1:0];
          depth_d    = CW'(1);
          top_node_d = root_q[IW-1:0];
          top_cur_d  = '0;
          adj_re     = 1'b1;
          adj_raddr  = root_q[IW-1:0];
          state_d    = S_STEP;
        end
      end

      S_STEP: begin
        if (top_cur_q >= n_eff) begin
          onstack_d[top_node_q] = 1'b0;
          depth_d = depth_q - 1'b1;
          if (depth_q == CW'(1)) begin
            root_d  = root_q + 1'b1;
            state_d = S_ROOT;
          end else begin
            nd_re    = 1'b1;
            nd_raddr = IW'(depth_q - CW'(2));
            state_d  = S_POP;
          end
        end else begin
          top_cur_d = top_cur_q + 1'b1;
          if (top_row[v_idx] && !visited_q[v_idx]) begin
            visited_d[v_idx] = 1'b1;
            onstack_d[v_idx] = 1'b1;
            cur_we     = 1'b1;
            cur_waddr  = IW'(depth_q - 1'b1);
            cur_wdata  = top_cur_q + 1'b1;
            nd_we      = 1'b1;
            nd_waddr   = IW'(depth_q);
            nd_wdata   = v_idx;
            depth_d    = depth_q + 1'b1;
            top_node_d = v_idx;
            top_cur_d  = '0;
            adj_re     = 1'b1;
            adj_raddr  = v_idx;
          end else if (top_row[v_idx] && onstack_q[v_idx]) begin
            // back edge: report the stack from the target up to the top
            total_d  = total_q + 1'b1;
            target_d = v_idx;
            idx_d    = '0;
            found_d  = 1'b0;
            nd_re    = 1'b1;
            nd_raddr = '0;
            state_d  = S_SCAN;
          end
        end
      end

      S_POP: begin
        top_node_d = nd_rdata;
        top_cur_d  = cur_rdata;
        adj_re     = 1'b1;
        adj_raddr  = nd_rdata;
        state_d    = S_STEP;
      end

      S_SCAN: begin
        if (found_q || nd_rdata == target_q) begin
          if (out_free) begin
            found_d   = 1'b1;
            emit      = 1'b1;
            emit_node = NodeW'(nd_rdata);
            emit_last = (idx_q == depth_q - 1'b1);
            if (emit_last) begin
              // tree abandoned; every on-stack mark belongs to it
              onstack_d = '0;
              depth_d   = '0;
              root_d    = root_q + 1'b1;
              state_d   = S_ROOT;
            end else begin
              idx_d    = idx_q + 1'b1;
              nd_re    = 1'b1;
              nd_raddr = IW'(idx_q + 1'b1);
            end
          end
        end else begin
          idx_d    = idx_q + 1'b1;
          nd_re    = 1'b1;
          nd_raddr = IW'(idx_q + 1'b1);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= 6'd32;
      row_valid_q  <= '0;
      visited_q    <= '0;
      onstack_q    <= '0;
      depth_q      <= '0;
      root_q       <= '0;
      found_q      <= 1'b0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      visited_q   <= visited_d;
      onstack_q   <= onstack_d;
      depth_q     <= depth_d;
      root_q      <= root_d;
      found_q     <= found_d;
      total_q     <= total_d;
      if (cfg_wr_en_i) begin
        node_count_q <= cfg_wr_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_node_q <= top_node_d;
    top_cur_q  <= top_cur_d;
    target_q   <= target_d;
    idx_q      <= idx_d;
    add_from_q <= add_from_d;
    add_to_q   <= add_to_d;
    if (emit) begin
      out_node_q <= emit_node;
      out_last_q <= emit_last;
      out_num_q  <= total_q;
      out_done_q <= emit_done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_num_q, out_node_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CW'(NODES))
    else $error("walk depth beyond node count");

  a_step_has_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP || state_q == S_SCAN || state_q == S_POP) |-> depth_q != '0)
    else $error("walk running on an empty stack");

  a_onstack_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (onstack_q & ~visited_q) == '0)
    else $error("on-stack node not marked visited");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result overwrites a pending result");
endmodule
